// ----- src/assert_macros.svh -----
// Assertion macros shared by the bar-graph scan-out RTL.
// Expects signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define SBFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SBFS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/sbfs_pkg.sv -----
// Package for the bar-graph frame store scan-out: geometry, codes,
// request/result structs and the thermometer encoder. No dependencies.
package sbfs_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = COL_W + 1;          // {buffer, column}
	localparam int ROWS   = 2 ** ROW_W;
	localparam int PAGE_W = $clog2(PAGES);
	localparam int POS_W  = 8;
	localparam int LINE_W = 8 * PAGES;          // one column across all pages

	// request command codes
	localparam logic [1:0] CMD_DRAW    = 2'd0;
	localparam logic [1:0] CMD_REFRESH = 2'd1;
	localparam logic [1:0] CMD_TICK    = 2'd2;

	// positions inside one page of the stream
	localparam logic [POS_W-1:0] POS_PAGE_CMD = 8'd0;
	localparam logic [POS_W-1:0] POS_COL_LO   = 8'd1;
	localparam logic [POS_W-1:0] POS_COL_HI   = 8'd2;
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(COLUMNS + 2);

	localparam logic [7:0] PANEL_PAGE_BASE = 8'hB0;
	localparam logic [7:0] PANEL_COL_HI    = 8'h10;

	typedef struct packed {
		logic [1:0] command;
		logic       buffer_select;
		logic [6:0] column;
		logic [7:0] amplitude;
	} req_t;

	typedef struct packed {
		logic       is_data;
		logic [7:0] byte_value;
		logic       page_end;
		logic       frame_end;
	} rsp_t;

	// one emitted byte as decided by the scan sequencer
	typedef struct packed {
		logic              valid;
		logic              is_data;
		logic [7:0]        cmd_byte;
		logic [PAGE_W-1:0] page;
		logic [ROW_W-1:0]  row;
		logic              page_end;
		logic              frame_end;
	} scan_req_t;

	// rows 0..amp lit for amp < 64, blank otherwise
	function automatic logic [LINE_W-1:0] thermometer(input logic [7:0] amp);
		logic [LINE_W-1:0] bits;
		bits = ~({{(LINE_W-1){1'b1}}, 1'b0} << amp[5:0]);
		if (amp[7:6] != 2'b00) begin
			bits = '0;
		end
		return bits;
	endfunction

endpackage

// ----- src/sbfs_store.sv -----
// Two-buffer frame store: one row per (buffer, column) holding all pages.
// Row valid bits give zero contents from reset. Uses sbfs_pkg.
module sbfs_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [sbfs_pkg::ROW_W-1:0]   wr_row,
	input  logic [sbfs_pkg::LINE_W-1:0]  wr_data,
	input  logic                         rd_en,
	input  logic [sbfs_pkg::ROW_W-1:0]   rd_row,
	output logic [sbfs_pkg::LINE_W-1:0]  rd_data
);
	import sbfs_pkg::*;

	logic [LINE_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   row_valid_q;
	logic [LINE_W-1:0] rd_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_row];
			end
		end
	end

	// never-drawn rows read as blank
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

// ----- src/sbfs_scan.sv -----
// Scan sequencer: walks pages, command bytes and reversed columns on ticks.
// Uses sbfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbfs_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_vld,
	input  logic [1:0]            command,
	input  logic                  buffer_select,
	input  logic [7:0]            column_offset,
	output sbfs_pkg::scan_req_t   scan
);
	import sbfs_pkg::*;

	logic              active_q;
	logic              buffer_q;
	logic [PAGE_W-1:0] page_q;
	logic [POS_W-1:0]  pos_q;

	logic              tick;
	logic              last_page;
	logic [POS_W:0]    col_diff;

	assign tick      = item_vld && (command == CMD_TICK) && active_q;
	assign last_page = (page_q == PAGE_W'(PAGES - 1));
	// data position p maps to column COLUMNS+2-p
	assign col_diff  = (POS_W+1)'(COLUMNS + 2) - {1'b0, pos_q};

	always_comb begin
		scan.valid     = tick;
		scan.page      = page_q;
		scan.row       = {buffer_q, col_diff[COL_W-1:0]};
		scan.is_data   = 1'b0;
		scan.page_end  = 1'b0;
		scan.frame_end = 1'b0;
		case (pos_q)
			POS_PAGE_CMD: scan.cmd_byte = PANEL_PAGE_BASE + 8'(page_q);
			POS_COL_LO:   scan.cmd_byte = {4'h0, column_offset[3:0]};
			POS_COL_HI:   scan.cmd_byte = PANEL_COL_HI | {4'h0, column_offset[7:4]};
			default: begin
				scan.cmd_byte  = '0;
				scan.is_data   = 1'b1;
				scan.page_end  = (pos_q >= POS_LAST);
				scan.frame_end = (pos_q >= POS_LAST) && last_page;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			buffer_q <= 1'b0;
			page_q   <= '0;
			pos_q    <= '0;
		end else if (item_vld && command == CMD_REFRESH) begin
			active_q <= 1'b1;
			buffer_q <= buffer_select;
			page_q   <= '0;
			pos_q    <= '0;
		end else if (tick) begin
			if (scan.page_end) begin
				pos_q <= '0;
				if (scan.frame_end) begin
					active_q <= 1'b0;
					page_q   <= '0;
				end else begin
					page_q <= page_q + 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	`SBFS_ASSERT_ALWAYS(a_idle_at_origin, !active_q |-> (page_q == '0 && pos_q == '0), "idle scan not parked at page 0 position 0")
	`SBFS_ASSERT(a_pos_in_range, pos_q <= POS_LAST, "scan position past last data byte")

endmodule

// ----- src/spectrum_bar_framebuffer_scanout_unit.sv -----
// Top level of the bar-graph frame store with paged-panel scan-out.
// Uses sbfs_pkg, sbfs_scan, sbfs_store and assert_macros.svh.
//
// Takes one request per clock (busy is always low). A draw writes one column
// of either buffer as a thermometer bar; a refresh arms a scan of one buffer;
// each tick of a running scan emits one stream byte on result, with strobe
// high for exactly one cycle, after the tick has passed the input register,
// the frame store registered read and the output register. The receiver
// cannot stall, so every strobe must be consumed. Stream order per page:
// page command, low then high column-offset nibble commands, then the page's
// column bytes from the last column down to column 0. Bytes reflect the store
// as it stands when each tick is processed, so draws may be interleaved with
// a scan. The store reads as zero right after reset with no clearing pass:
// a valid flag per (buffer, column) row masks rows never drawn.
`include "assert_macros.svh"

module spectrum_bar_framebuffer_scanout_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sbfs_pkg::req_t   req,
	output logic             strobe,
	output sbfs_pkg::rsp_t   result,
	input  logic             offset_we,
	input  logic [7:0]       offset_data
);
	import sbfs_pkg::*;

	logic              accept;
	logic              item_vld_s1;
	req_t              req_s1;
	logic [7:0]        column_offset_q;

	scan_req_t         scan;
	scan_req_t         scan_s2;

	logic              draw_en;
	logic [LINE_W-1:0] rd_data;

	logic              strobe_q;
	rsp_t              result_q;

	// every request is taken on arrival
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// column offset register, reset to panel column 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_offset_q <= 8'd2;
		end else if (offset_we) begin
			column_offset_q <= offset_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else begin
			item_vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// draws past the last column are dropped
	assign draw_en = item_vld_s1 && (req_s1.command == CMD_DRAW)
		&& ({1'b0, req_s1.column} < 8'(COLUMNS));

	sbfs_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_vld      (item_vld_s1),
		.command       (req_s1.command),
		.buffer_select (req_s1.buffer_select),
		.column_offset (column_offset_q),
		.scan          (scan)
	);

	sbfs_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (draw_en),
		.wr_row  ({req_s1.buffer_select, COL_W'(req_s1.column)}),
		.wr_data (thermometer(req_s1.amplitude)),
		.rd_en   (scan.valid && scan.is_data),
		.rd_row  (scan.row),
		.rd_data (rd_data)
	);

	// stage 2: scan decision waits alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s2 <= '0;
		end else begin
			scan_s2 <= scan;
		end
	end

	// output register: pick the page byte out of the column word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= scan_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_s2.valid) begin
			result_q.is_data    <= scan_s2.is_data;
			result_q.byte_value <= scan_s2.is_data ? rd_data[scan_s2.page*8 +: 8]
				: scan_s2.cmd_byte;
			result_q.page_end   <= scan_s2.page_end;
			result_q.frame_end  <= scan_s2.frame_end;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`SBFS_ASSERT(a_strobe_from_tick, strobe |-> $past(accept && req.command == CMD_TICK, 3), "result without a tick three cycles earlier")
	`SBFS_ASSERT(a_frame_end_on_page_end, (strobe && result.frame_end) |-> (result.page_end && result.is_data), "frame end not on last data byte of a page")

endmodule

// ----- tb/tb_spectrum_bar_framebuffer_scanout_unit.sv -----
// Self-checking bench for the bar-graph frame store with paged-panel scan-out.
// Needs sbfs_pkg and spectrum_bar_framebuffer_scanout_unit; predicts every stream
// byte from a mirror of the store and checks it as it leaves the block.
module tb_spectrum_bar_framebuffer_scanout_unit;
	import sbfs_pkg::*;

	// command 3 has no meaning and must be dropped silently
	localparam logic [1:0] CMD_IGNORED = 2'd3;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 12;
	localparam int TIMEOUT_CYCLES = 200_000;
	localparam int REPORT_LIMIT   = 10;
	localparam int FRAME_TICKS    = PAGES * (COLUMNS + 3);

	typedef enum logic {ENTRY_REQUEST, ENTRY_OFFSET} entry_kind_t;

	typedef struct {
		entry_kind_t kind;
		req_t        req;
		logic [7:0]  offset;
		int unsigned idle_pct;
	} pending_entry_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       req = '0;
	logic       strobe;
	rsp_t       result;
	logic       offset_we = 1'b0;
	logic [7:0] offset_data = '0;

	pending_entry_t request_backlog[$];
	rsp_t           panel_bytes_due[$];
	int             quiet_cycles;
	int             mismatch_count = 0;

	// mirror of the block's state
	logic [7:0]        mirror_pixels [2][PAGES][COLUMNS];
	logic [7:0]        mirror_offset;
	logic              stream_running;
	logic              stream_buffer;
	logic [PAGE_W-1:0] stream_page;
	logic [POS_W-1:0]  stream_step;

	spectrum_bar_framebuffer_scanout_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.strobe      (strobe),
		.result      (result),
		.offset_we   (offset_we),
		.offset_data (offset_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- mirror

	function automatic logic [LINE_W-1:0] bar_bits(input logic [7:0] amp);
		logic [LINE_W:0] ones;
		if (amp >= 8'd64) begin
			return '0;
		end
		ones = ({{LINE_W{1'b0}}, 1'b1} << (amp + 8'd1)) - 1'b1;
		return ones[LINE_W-1:0];
	endfunction

	task automatic clear_mirror();
		for (int b = 0; b < 2; b++) begin
			for (int p = 0; p < PAGES; p++) begin
				for (int c = 0; c < COLUMNS; c++) begin
					mirror_pixels[b][p][c] = '0;
				end
			end
		end
		mirror_offset  = 8'd2;
		stream_running = 1'b0;
		stream_buffer  = 1'b0;
		stream_page    = '0;
		stream_step    = '0;
	endtask

	// apply one accepted request; a tick of a running scan queues the byte it sends
	task automatic predict_request(input req_t r);
		logic [LINE_W-1:0] bits;
		rsp_t              out;
		int                col;
		bits = '0;
		out  = '0;
		case (r.command)
			CMD_DRAW: begin
				bits = bar_bits(r.amplitude);
				for (int p = 0; p < PAGES; p++) begin
					mirror_pixels[r.buffer_select][p][r.column] = bits[8*p +: 8];
				end
			end
			CMD_REFRESH: begin
				stream_running = 1'b1;
				stream_buffer  = r.buffer_select;
				stream_page    = '0;
				stream_step    = '0;
			end
			CMD_TICK: begin
				if (stream_running) begin
					if (stream_step == POS_PAGE_CMD) begin
						out.byte_value = PANEL_PAGE_BASE + 8'(stream_page);
					end else if (stream_step == POS_COL_LO) begin
						out.byte_value = {4'h0, mirror_offset[3:0]};
					end else if (stream_step == POS_COL_HI) begin
						out.byte_value = PANEL_COL_HI | {4'h0, mirror_offset[7:4]};
					end else begin
						// data runs from the last column down to column 0
						col            = COLUMNS - 1 - (int'(stream_step) - 3);
						out.is_data    = 1'b1;
						out.byte_value = mirror_pixels[stream_buffer][stream_page][col];
						out.page_end   = (stream_step == POS_LAST);
						out.frame_end  = out.page_end && (stream_page == PAGE_W'(PAGES - 1));
					end
					if (out.page_end) begin
						stream_step = '0;
						if (out.frame_end) begin
							stream_running = 1'b0;
							stream_page    = '0;
						end else begin
							stream_page = stream_page + 1'b1;
						end
					end else begin
						stream_step = stream_step + 1'b1;
					end
					panel_bytes_due.push_back(out);
				end
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- driver
	// Requests go out one per cycle unless the phase's idle draw says otherwise.
	// An offset write waits for the stream to drain and a few quiet cycles.
	always @(posedge clk or negedge arst_n) begin
		pending_entry_t head;
		logic           took;
		if (!arst_n) begin
			start        <= 1'b0;
			req          <= '0;
			offset_we    <= 1'b0;
			offset_data  <= '0;
			quiet_cycles <= 0;
			clear_mirror();
		end else begin
			took = start && !busy;
			if (offset_we) begin
				mirror_offset = offset_data;
			end
			if (took) begin
				predict_request(req);
			end
			if (start || panel_bytes_due.size() != 0) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end

			if (start && !took) begin
				offset_we <= 1'b0;
			end else if (request_backlog.size() == 0) begin
				start     <= 1'b0;
				offset_we <= 1'b0;
			end else begin
				head = request_backlog[0];
				if (head.kind == ENTRY_OFFSET) begin
					start <= 1'b0;
					if (!offset_we && quiet_cycles >= SETTLE_CYCLES
							&& panel_bytes_due.size() == 0) begin
						offset_we   <= 1'b1;
						offset_data <= head.offset;
						void'(request_backlog.pop_front());
					end else begin
						offset_we <= 1'b0;
					end
				end else begin
					offset_we <= 1'b0;
					if ($urandom_range(99, 0) < head.idle_pct) begin
						start <= 1'b0;
					end else begin
						start <= 1'b1;
						req   <= head.req;
						void'(request_backlog.pop_front());
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && strobe) begin
			if (panel_bytes_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT) begin
					$display("mismatch at %0t: byte with nothing due, got %p", $realtime, result);
				end
			end else begin
				want = panel_bytes_due.pop_front();
				if (result.is_data !== want.is_data || result.byte_value !== want.byte_value
						|| result.page_end !== want.page_end
						|| result.frame_end !== want.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("mismatch at %0t: expected %p, got %p", $realtime, want, result);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic push_request(input logic [1:0] cmd, input logic sel,
			input logic [6:0] col, input logic [7:0] amp, input int unsigned pct);
		pending_entry_t e;
		e.kind              = ENTRY_REQUEST;
		e.req.command       = cmd;
		e.req.buffer_select = sel;
		e.req.column        = col;
		e.req.amplitude     = amp;
		e.offset            = '0;
		e.idle_pct          = pct;
		request_backlog.push_back(e);
	endtask

	task automatic push_offset(input logic [7:0] value);
		pending_entry_t e;
		e.kind     = ENTRY_OFFSET;
		e.req      = '0;
		e.offset   = value;
		e.idle_pct = 0;
		request_backlog.push_back(e);
	endtask

	// half the bars land in range, the rest span all heights, blanking ones included
	task automatic push_random_draw(input int unsigned pct);
		logic [7:0] amp;
		amp = $urandom_range(1, 0) ? 8'($urandom_range(63, 0)) : 8'($urandom_range(255, 0));
		push_request(CMD_DRAW, 1'($urandom_range(1, 0)), 7'($urandom_range(127, 0)), amp, pct);
	endtask

	// ticks with a sprinkling of draws into either buffer
	task automatic push_scan_run(input int ticks, input int unsigned pct,
			input int unsigned draw_pct);
		int sent;
		sent = 0;
		while (sent < ticks) begin
			if ($urandom_range(99, 0) < draw_pct) begin
				push_random_draw(pct);
			end else begin
				push_request(CMD_TICK, 1'($urandom_range(1, 0)), 7'($urandom()),
					8'($urandom()), pct);
				sent++;
			end
		end
	endtask

	// mostly refresh, a few draws, then a run of ticks; the rest is noise
	task automatic push_random_phase(input int budget, input int unsigned pct);
		int base;
		int pick;
		base = request_backlog.size();
		while (request_backlog.size() - base < budget) begin
			pick = $urandom_range(99, 0);
			if (pick < 85) begin
				repeat ($urandom_range(6, 0)) push_random_draw(pct);
				push_request(CMD_REFRESH, 1'($urandom_range(1, 0)), 7'($urandom()),
					8'($urandom()), pct);
				push_scan_run($urandom_range(1, 0) ? $urandom_range(40, 1)
					: $urandom_range(140, 125), pct, 10);
			end else if (pick < 92) begin
				push_request(CMD_IGNORED, 1'($urandom_range(1, 0)), 7'($urandom()),
					8'($urandom()), pct);
			end else begin
				push_random_draw(pct);
			end
		end
	endtask

	initial begin
		// directed part: reset offset, bar extremes, idle tick, command 3,
		// draw mid-scan and a refresh that drops a running scan
		push_request(CMD_TICK, 1'b0, 7'd0, 8'd0, 38);
		push_request(CMD_IGNORED, 1'b1, 7'd127, 8'd255, 38);
		push_request(CMD_DRAW, 1'b0, 7'd127, 8'd0, 38);
		push_request(CMD_DRAW, 1'b0, 7'd126, 8'd31, 38);
		push_request(CMD_DRAW, 1'b0, 7'd125, 8'd32, 38);
		push_request(CMD_DRAW, 1'b0, 7'd124, 8'd63, 38);
		push_request(CMD_DRAW, 1'b0, 7'd123, 8'd64, 38);
		push_request(CMD_DRAW, 1'b0, 7'd0, 8'd255, 38);
		push_request(CMD_DRAW, 1'b1, 7'd127, 8'd7, 38);
		push_request(CMD_DRAW, 1'b1, 7'd126, 8'd128, 38);
		push_request(CMD_REFRESH, 1'b1, 7'd0, 8'd0, 38);
		push_scan_run(5, 38, 0);
		push_request(CMD_DRAW, 1'b1, 7'd125, 8'd40, 38);
		push_scan_run(2, 38, 0);
		push_request(CMD_REFRESH, 1'b0, 7'd0, 8'd0, 38);
		push_scan_run(8, 38, 0);

		push_offset(8'd131);
		push_random_phase(60, 38);
		push_offset(8'd0);
		push_random_phase(60, 66);
		// full frame with no sender gaps, ending in frame_end, then dead ticks
		push_offset(8'd124);
		repeat (12) push_random_draw(0);
		push_request(CMD_REFRESH, 1'($urandom_range(1, 0)), 7'd0, 8'd0, 0);
		push_scan_run(FRAME_TICKS + 3, 0, 2);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || start || offset_we) @(posedge clk);
		while (panel_bytes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
